// ----- sv/fcs_pkg.sv -----
package fcs_pkg;

  localparam int STACK_DEPTH = 8;
  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

  localparam int KIND_W = 2;
  localparam int CHAR_W = 8;
  localparam int STATUS_W = 3;
  localparam int FIELD_CNT_W = 4;

  typedef enum logic [KIND_W-1:0] {
    K_PUSH  = 2'd0,
    K_POP   = 2'd1,
    K_COUNT = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_NOTLETTER = 3'd3,
    ST_REPEAT    = 3'd4
  } status_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  function automatic logic is_letter(input logic [CHAR_W-1:0] b);
    return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
  endfunction

endpackage

// ----- sv/fcs_mem.sv -----
module fcs_mem
  import fcs_pkg::*;
(
  input  logic              clk,
  input  mem_req_t          req,
  output logic [CHAR_W-1:0] rd_data
);

  logic [CHAR_W-1:0] mem [STACK_DEPTH];
  logic [CHAR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/filtered_char_stack_unit.sv -----
// Channel    Ports                                                   Handshake
// request    in_kind, in_char_value                                  start & !busy
// result     out_status, out_popped_char, out_match_count,           out_strobe, one cycle
//            out_fill_level
//
// One request is worked on at a time; busy is high until its result is produced.
// A refused push, a request on an empty stack and the unused kind give their
// result in the cycle after acceptance, as does a push onto an empty stack.
// Other pushes and pops pass through S_PUSH or S_POP before their result, because
// the top entry comes from the single registered read port of the entry memory.
// A count sweeps that read port over the occupied entries in S_COUNT.
// Reset clears only state, occupancy and strobe; entries stay undefined until written.
// The result is held for exactly one cycle and the receiver cannot stall it.
module filtered_char_stack_unit
  import fcs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [KIND_W-1:0]      in_kind,
  input  logic [CHAR_W-1:0]      in_char_value,
  output logic                   out_strobe,
  output logic [STATUS_W-1:0]    out_status,
  output logic [CHAR_W-1:0]      out_popped_char,
  output logic [FIELD_CNT_W-1:0] out_match_count,
  output logic [FIELD_CNT_W-1:0] out_fill_level
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PUSH  = 4'b0010,
    S_POP   = 4'b0100,
    S_COUNT = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       occ_r, occ_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CHAR_W-1:0]      char_r, char_nxt;
  logic                   strobe_r, strobe_nxt;
  status_t                status_r, status_nxt;
  logic [CHAR_W-1:0]      popped_r, popped_nxt;
  logic [FIELD_CNT_W-1:0] match_r, match_nxt;
  logic [FIELD_CNT_W-1:0] fill_r, fill_nxt;

  mem_req_t               mreq;
  logic [CHAR_W-1:0]      rd_data;
  logic [CNT_W-1:0]       occ_dec;
  logic [CNT_W-1:0]       cnt_sum;
  logic                   accept;

  fcs_mem u_mem (
    .clk     (clk),
    .req     (mreq),
    .rd_data (rd_data)
  );

  assign accept  = start && (state_r == S_IDLE);
  assign occ_dec = occ_r - 1'b1;
  assign cnt_sum = cnt_r + CNT_W'(rd_data == char_r);

  always_comb begin
    state_nxt  = state_r;
    occ_nxt    = occ_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    char_nxt   = char_r;
    strobe_nxt = 1'b0;
    status_nxt = ST_OK;
    popped_nxt = '0;
    match_nxt  = '0;
    mreq.we    = 1'b0;
    mreq.waddr = occ_r[ADDR_W-1:0];
    mreq.wdata = char_r;
    mreq.raddr = occ_dec[ADDR_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          char_nxt = in_char_value;
          case (in_kind)
            K_PUSH: begin
              if (occ_r == DEPTH_CNT) begin
                strobe_nxt = 1'b1;
                status_nxt = ST_OVERFLOW;
              end else if (!is_letter(in_char_value)) begin
                strobe_nxt = 1'b1;
                status_nxt = ST_NOTLETTER;
              end else if (occ_r == '0) begin
                mreq.we    = 1'b1;
                mreq.wdata = in_char_value;
                occ_nxt    = occ_r + 1'b1;
                strobe_nxt = 1'b1;
              end else begin
                state_nxt = S_PUSH;
              end
            end
            K_POP: begin
              if (occ_r == '0) begin
                strobe_nxt = 1'b1;
                status_nxt = ST_UNDERFLOW;
              end else begin
                state_nxt = S_POP;
              end
            end
            K_COUNT: begin
              if (occ_r == '0) begin
                strobe_nxt = 1'b1;
                status_nxt = ST_UNDERFLOW;
              end else begin
                mreq.raddr = '0;
                idx_nxt    = CNT_W'(1);
                cnt_nxt    = '0;
                state_nxt  = S_COUNT;
              end
            end
            default: begin
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      S_PUSH: begin
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
        if (rd_data == char_r) begin
          status_nxt = ST_REPEAT;
        end else begin
          mreq.we = 1'b1;
          occ_nxt = occ_r + 1'b1;
        end
      end
      S_POP: begin
        strobe_nxt = 1'b1;
        popped_nxt = rd_data;
        occ_nxt    = occ_dec;
        state_nxt  = S_IDLE;
      end
      S_COUNT: begin
        cnt_nxt = cnt_sum;
        if (idx_r < occ_r) begin
          mreq.raddr = idx_r[ADDR_W-1:0];
          idx_nxt    = idx_r + 1'b1;
        end else begin
          strobe_nxt = 1'b1;
          match_nxt  = FIELD_CNT_W'(cnt_sum);
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    fill_nxt = FIELD_CNT_W'(occ_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      occ_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      occ_r    <= occ_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    cnt_r    <= cnt_nxt;
    char_r   <= char_nxt;
    status_r <= status_nxt;
    popped_r <= popped_nxt;
    match_r  <= match_nxt;
    fill_r   <= fill_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_popped_char = popped_r;
  assign out_match_count = match_r;
  assign out_fill_level  = fill_r;

  // The occupancy never exceeds the stack depth.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= DEPTH_CNT)
    else $error("occupancy above stack depth");

  // An entry is written only into a free slot.
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    mreq.we |-> (occ_r < DEPTH_CNT))
    else $error("entry written on a full stack");

  // A pop on an empty stack reports underflow in the next cycle.
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_kind == K_POP) && (occ_r == '0))
      |=> (out_strobe && (out_status == ST_UNDERFLOW)))
    else $error("pop on empty stack did not underflow");

  // A result is produced only when the unit returns to idle.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_nxt |-> (state_nxt == S_IDLE))
    else $error("result produced while request still in progress");

endmodule
